### rtl/min_resources_interval_heap_unit_macros.svh
// Assertion macros shared by the heap unit
`ifndef MIN_RESOURCES_INTERVAL_HEAP_UNIT_MACROS_SVH
`define MIN_RESOURCES_INTERVAL_HEAP_UNIT_MACROS_SVH
// implication checked every edge outside reset
`define MRIH_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mrih check failed");
// implication checked in the cycle after the antecedent
`define MRIH_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mrih check failed");
`endif

### rtl/mrih_pkg.sv
// Shared types and constants for the interval heap unit
package mrih_pkg;
  localparam int HEAP_DEPTH = 1024;
  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = 11;
  localparam int TW = 32;
  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [TW-1:0] arrival;
    logic [TW-1:0] departure;
    logic          last;
  } job_t;

  typedef struct packed {
    logic [CW-1:0] in_use;
    logic [CW-1:0] peak;
    logic          drop;
    logic          last;
  } res_t;
endpackage

### rtl/mrih_front.sv
// Input stage: takes input beats and queues them for the heap engine
module mrih_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [63:0]         in_tdata,
  input  logic                in_tlast,
  output logic                q_valid,
  input  logic                q_pop,
  output mrih_pkg::job_t      q_job
);
  mrih_pkg::job_t mem_r [mrih_pkg::QDEPTH];
  logic wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic push;

  assign in_tready = (cnt_r != 2'(mrih_pkg::QDEPTH));
  assign push = in_tvalid && in_tready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_job = mem_r[rp_r];

  always_comb begin
    wp_nxt = wp_r + 1'(push);
    rp_nxt = rp_r + 1'(q_pop);
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{arrival: in_tdata[31:0], departure: in_tdata[63:32], last: in_tlast};
    end
  end
endmodule

### rtl/mrih_engine.sv
// Heap engine: pops expired departures, pushes new one unless the heap is full, tracks peak
module mrih_engine (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_pop,
  input  mrih_pkg::job_t q_job,
  output logic           res_valid,
  input  logic           res_take,
  output mrih_pkg::res_t res
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TOPRD = 4'd1;
  localparam logic [3:0] S_TOPCK = 4'd2;
  localparam logic [3:0] S_POPLD = 4'd3;
  localparam logic [3:0] S_DNRD  = 4'd4;
  localparam logic [3:0] S_DNRD2 = 4'd5;
  localparam logic [3:0] S_DNCK  = 4'd6;
  localparam logic [3:0] S_UPRD  = 4'd7;
  localparam logic [3:0] S_UPCK  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [mrih_pkg::TW-1:0] heap_r [mrih_pkg::HEAP_DEPTH];
  logic [3:0] st_r, st_nxt;
  logic [mrih_pkg::CW-1:0] cnt_r, cnt_nxt, peak_r, peak_nxt;
  logic [mrih_pkg::AW:0] pos_r, pos_nxt;
  logic [mrih_pkg::TW-1:0] cur_r, cur_nxt, rd_r, lc_r, lc_nxt;
  logic drop_r, drop_nxt;
  mrih_pkg::job_t job_r;
  mrih_pkg::res_t res_r, res_nxt;
  logic res_v_r, res_v_nxt;
  logic [mrih_pkg::AW-1:0] ra, wa;
  logic we;
  logic [mrih_pkg::TW-1:0] wd;
  logic [mrih_pkg::AW:0] lc_i, rc_i, up_i;

  assign q_pop = (st_r == S_IDLE) && q_valid;
  assign res_valid = res_v_r;
  assign res = res_r;
  assign lc_i = {pos_r[mrih_pkg::AW-1:0], 1'b1};
  assign rc_i = lc_i + 1'b1;
  assign up_i = (pos_r - 1'b1) >> 1;

  always_ff @(posedge clk) begin
    if (we) heap_r[wa] <= wd;
    rd_r <= heap_r[ra];
  end

  always_ff @(posedge clk) begin
    if (q_pop) job_r <= q_job;
  end

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; peak_nxt = peak_r;
    pos_nxt = pos_r; cur_nxt = cur_r; lc_nxt = lc_r;
    drop_nxt = drop_r; res_nxt = res_r; res_v_nxt = res_v_r;
    ra = '0; wa = '0; we = 1'b0; wd = cur_r;
    if (res_take) res_v_nxt = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (q_pop) st_nxt = S_TOPRD;
      end
      S_TOPRD: begin
        ra = '0;
        st_nxt = S_TOPCK;
      end
      S_TOPCK: begin
        if (cnt_r != '0 && rd_r < job_r.arrival) begin
          cnt_nxt = cnt_r - 1'b1;
          ra = mrih_pkg::AW'(cnt_r - 1'b1);
          st_nxt = S_POPLD;
        end else if (cnt_r >= mrih_pkg::CW'(mrih_pkg::HEAP_DEPTH)) begin
          drop_nxt = 1'b1;
          st_nxt = S_DONE;
        end else begin
          drop_nxt = 1'b0;
          cur_nxt = job_r.departure;
          pos_nxt = (mrih_pkg::AW+1)'(cnt_r);
          cnt_nxt = cnt_r + 1'b1;
          st_nxt = S_UPRD;
        end
      end
      S_POPLD: begin
        // moved last element; sift down from root
        cur_nxt = rd_r;
        pos_nxt = '0;
        st_nxt = S_DNRD;
      end
      S_DNRD: begin
        if ({1'b0, lc_i} >= {1'b0, (mrih_pkg::AW+1)'(cnt_r)} || lc_i[mrih_pkg::AW]) begin
          we = 1'b1; wa = pos_r[mrih_pkg::AW-1:0];
          st_nxt = S_TOPRD;
        end else begin
          ra = lc_i[mrih_pkg::AW-1:0];
          st_nxt = S_DNRD2;
        end
      end
      S_DNRD2: begin
        lc_nxt = rd_r;
        ra = rc_i[mrih_pkg::AW-1:0];
        st_nxt = S_DNCK;
      end
      S_DNCK: begin
        if (rc_i < (mrih_pkg::AW+1)'(cnt_r) && rd_r < lc_r && rd_r < cur_r) begin
          we = 1'b1; wa = pos_r[mrih_pkg::AW-1:0]; wd = rd_r;
          pos_nxt = rc_i; st_nxt = S_DNRD;
        end else if (lc_r < cur_r) begin
          we = 1'b1; wa = pos_r[mrih_pkg::AW-1:0]; wd = lc_r;
          pos_nxt = lc_i; st_nxt = S_DNRD;
        end else begin
          we = 1'b1; wa = pos_r[mrih_pkg::AW-1:0];
          st_nxt = S_TOPRD;
        end
      end
      S_UPRD: begin
        if (pos_r == '0) begin
          we = 1'b1; wa = '0;
          st_nxt = S_DONE;
        end else begin
          ra = up_i[mrih_pkg::AW-1:0];
          st_nxt = S_UPCK;
        end
      end
      S_UPCK: begin
        we = 1'b1; wa = pos_r[mrih_pkg::AW-1:0];
        if (cur_r < rd_r) begin
          wd = rd_r; pos_nxt = up_i; st_nxt = S_UPRD;
        end else begin
          st_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (cnt_r > peak_r) peak_nxt = cnt_r;
        st_nxt = S_OUT;
      end
      S_OUT: begin
        if (!res_v_r || res_take) begin
          res_nxt = '{in_use: cnt_r, peak: peak_r, drop: drop_r, last: job_r.last};
          res_v_nxt = 1'b1;
          if (job_r.last) begin
            cnt_nxt = '0; peak_nxt = '0;
          end
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; cnt_r <= '0; peak_r <= '0; res_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; peak_r <= peak_nxt; res_v_r <= res_v_nxt;
    end
    pos_r <= pos_nxt; cur_r <= cur_nxt; lc_r <= lc_nxt;
    drop_r <= drop_nxt; res_r <= res_nxt;
  end
endmodule

### rtl/min_resources_interval_heap_unit.sv
// Each interval reads the heap top, then walks down the heap level by level for every pop
// of an expired departure and up level by level on the push sift-up; the single-port
// heap memory (one read per cycle, registered) sets their pace. A two-entry input queue takes
// beats while the engine works, and the result register lets the engine start the next
// interval while a result beat waits. Heap memory needs no clearing after reset.
module min_resources_interval_heap_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // arrival_time, departure_time
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // in_use, peak_in_use, full_drop, zero fill
  output logic        out_tlast
);
  `include "min_resources_interval_heap_unit_macros.svh"

  logic q_valid, q_pop;
  mrih_pkg::job_t q_job;
  mrih_pkg::res_t res;

  mrih_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .q_valid, .q_pop, .q_job
  );

  mrih_engine u_engine (
    .clk, .rst_n, .q_valid, .q_pop, .q_job,
    .res_valid(out_tvalid), .res_take(out_tready), .res
  );

  assign out_tdata = {1'b0, res.drop, res.peak, res.in_use};
  assign out_tlast = res.last;

  `MRIH_ASSERT_IMP(a_peak_ge_use, out_tvalid, res.peak >= res.in_use)
  `MRIH_ASSERT_IMP(a_use_bound, out_tvalid, res.in_use <= 11'(mrih_pkg::HEAP_DEPTH))
  `MRIH_ASSERT_NXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
endmodule
